// File: hdl/vector3_normalize_core_defines.svh
// Assertion macros shared by the vector normalize core.
// Included by the top level; uses its clock and reset ports.
`ifndef VECTOR3_NORMALIZE_CORE_DEFINES_SVH
`define VECTOR3_NORMALIZE_CORE_DEFINES_SVH

// Clocked property, disabled while reset is high.
`define V3N_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("v3n check failed");

// Same-cycle implication.
`define V3N_ASSERT_IMPL(lbl, ante, cons) \
   `V3N_ASSERT(lbl, (ante) |-> (cons))

`endif

// File: hdl/v3n_pkg.sv
// Shared constants for the vector normalize core.
// No dependencies.
`default_nettype none
package v3n_pkg;
   localparam int FIELD_W   = 32;  // width of every port field
   localparam int UNIT_FRAC = 30;  // fraction bits of the unit vector
   localparam int QUOT_W    = UNIT_FRAC + 1;  // quotient reaches 1.0
   localparam int LANES     = 3;
endpackage
`default_nettype wire

// File: hdl/vector3_normalize_core.sv
// Vector normalize core: magnitude and unit vector of a 3D fixed point vector.
// Slave channel req_* takes one vector per word (x, y, z, Q16.16).
// Master channel rsp_* gives one result word per vector: unit x, y, z in
// Q2.30, length in Q16.16 (root rounded down), and a zero flag in tuser.
// The pipeline has three front stages (magnitude, squares, sum), one square
// root cell per root bit, 31 divider cells, then the output register.
// Throughput is one vector per cycle while the output is not stalled;
// every cell of both chains then takes a new word each cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops; nothing is lost.
// Reset clears the valid bits only; payload registers are not reset.
// Only the low COMP_WIDTH bits of each component are used, sign extended.
// Depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell and the defines header.
`default_nettype none
`include "vector3_normalize_core_defines.svh"
module vector3_normalize_core
   import v3n_pkg::*;
#(
   parameter int COMP_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // comp_x, comp_y, comp_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // unit_x, unit_y, unit_z, length
   output logic [0:0]        rsp_tuser    // is_zero
);
   localparam int W      = COMP_WIDTH;
   localparam int SIDE_W = LANES * W + LANES;

   logic enable;

   // front stages
   logic                 v0_ff, v1_ff, v2_ff;
   logic [LANES*W-1:0]   mag0_ff, mag1_ff, mag2_ff, mag_in;
   logic [LANES-1:0]     neg0_ff, neg1_ff, neg2_ff, neg_in;
   logic [2*W-1:0]       sq1_ff [LANES];
   logic [2*W-1:0]       sum2_ff;

   always_comb begin
      logic [W-1:0] v;
      for (int i = 0; i < LANES; i++) begin
         v = req_tdata[i*FIELD_W +: W];
         neg_in[i] = v[W-1];
         mag_in[i*W +: W] = v[W-1] ? W'(~v + 1'b1) : v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag0_ff <= mag_in;
         neg0_ff <= neg_in;
         for (int i = 0; i < LANES; i++) begin
            sq1_ff[i] <= mag0_ff[i*W +: W] * mag0_ff[i*W +: W];
         end
         mag1_ff <= mag0_ff;
         neg1_ff <= neg0_ff;
         sum2_ff <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // square root chain
   logic              sr_valid [0:W];
   logic [2*W-1:0]    sr_rad   [0:W];
   logic [W+1:0]      sr_rem   [0:W];
   logic [W-1:0]      sr_root  [0:W];
   logic [SIDE_W-1:0] sr_side  [0:W];

   assign sr_valid[0] = v2_ff;
   assign sr_rad[0]   = sum2_ff;
   assign sr_rem[0]   = '0;
   assign sr_root[0]  = '0;
   assign sr_side[0]  = {neg2_ff, mag2_ff};

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      v3n_sqrt_cell #(.W(W), .SIDE_W(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (sr_valid[k]),
         .rad_in   (sr_rad[k]),
         .rem_in   (sr_rem[k]),
         .root_in  (sr_root[k]),
         .side_in  (sr_side[k]),
         .valid_out(sr_valid[k+1]),
         .rad_out  (sr_rad[k+1]),
         .rem_out  (sr_rem[k+1]),
         .root_out (sr_root[k+1]),
         .side_out (sr_side[k+1])
      );
   end

   // divider chain; side word is {zero, neg, len}
   logic                    dv_valid [0:QUOT_W];
   logic [LANES*W-1:0]      dv_rem   [0:QUOT_W];
   logic [LANES*QUOT_W-1:0] dv_quot  [0:QUOT_W];
   logic [W+3:0]            dv_side  [0:QUOT_W];

   assign dv_valid[0] = sr_valid[W];
   assign dv_rem[0]   = sr_side[W][LANES*W-1:0];
   assign dv_quot[0]  = '0;
   assign dv_side[0]  = {(sr_root[W] == '0), sr_side[W][SIDE_W-1 -: LANES], sr_root[W]};

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      v3n_div_cell #(.W(W), .FIRST(k == 0)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (dv_valid[k]),
         .rem_in   (dv_rem[k]),
         .quot_in  (dv_quot[k]),
         .side_in  (dv_side[k]),
         .valid_out(dv_valid[k+1]),
         .rem_out  (dv_rem[k+1]),
         .quot_out (dv_quot[k+1]),
         .side_out (dv_side[k+1])
      );
   end

   // output register
   logic         out_valid_ff;
   logic [127:0] out_data_ff, out_data_in;
   logic         out_zero_ff;
   logic         fin_zero;
   logic [LANES-1:0] fin_neg;

   assign fin_zero = dv_side[QUOT_W][W+3];
   assign fin_neg  = dv_side[QUOT_W][W+2:W];

   always_comb begin
      logic [FIELD_W-1:0] q;
      for (int i = 0; i < LANES; i++) begin
         q = FIELD_W'(dv_quot[QUOT_W][i*QUOT_W +: QUOT_W]);
         if (fin_zero) begin
            out_data_in[i*FIELD_W +: FIELD_W] = '0;
         end else if (fin_neg[i]) begin
            out_data_in[i*FIELD_W +: FIELD_W] = FIELD_W'(~q + 1'b1);
         end else begin
            out_data_in[i*FIELD_W +: FIELD_W] = q;
         end
      end
      out_data_in[LANES*FIELD_W +: FIELD_W] = FIELD_W'(dv_side[QUOT_W][W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= dv_valid[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_data_ff <= out_data_in;
         out_zero_ff <= fin_zero;
      end
   end

   assign enable     = !out_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zero_ff;

   `V3N_ASSERT_IMPL(a_zero_clears, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `V3N_ASSERT_IMPL(a_len_nonzero, rsp_tvalid && !rsp_tuser[0], rsp_tdata[127:96] != '0)
   `V3N_ASSERT_IMPL(a_unit_range, rsp_tvalid,
      ($signed(rsp_tdata[31:0]) <= 32'sd1073741824) &&
      ($signed(rsp_tdata[31:0]) >= -32'sd1073741824))
endmodule
`default_nettype wire

// File: hdl/v3n_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// Uses no package items.
`default_nettype none
module v3n_sqrt_cell #(
   parameter int W      = 32,
   parameter int SIDE_W = 99
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              valid_in,
   input  wire logic [2*W-1:0]    rad_in,
   input  wire logic [W+1:0]      rem_in,
   input  wire logic [W-1:0]      root_in,
   input  wire logic [SIDE_W-1:0] side_in,
   output logic                   valid_out,
   output logic [2*W-1:0]         rad_out,
   output logic [W+1:0]           rem_out,
   output logic [W-1:0]           root_out,
   output logic [SIDE_W-1:0]      side_out
);
   logic              valid_ff;
   logic [2*W-1:0]    rad_ff, rad_in_nx;
   logic [W+1:0]      rem_ff, rem_in_nx;
   logic [W-1:0]      root_ff, root_in_nx;
   logic [SIDE_W-1:0] side_ff;
   logic [W+3:0]      rem_cat;
   logic [W+3:0]      trial;

   always_comb begin
      rem_cat   = {rem_in, rad_in[2*W-1 -: 2]};
      trial     = (W+4)'({root_in, 2'b01});
      rad_in_nx = {rad_in[2*W-3:0], 2'b00};
      if (rem_cat >= trial) begin
         rem_in_nx  = (W+2)'(rem_cat - trial);
         root_in_nx = {root_in[W-2:0], 1'b1};
      end else begin
         rem_in_nx  = (W+2)'(rem_cat);
         root_in_nx = {root_in[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in_nx;
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

// File: hdl/v3n_div_cell.sv
// One cell of the divider chain: one quotient bit for each of three lanes.
// Depends on v3n_pkg.
`default_nettype none
module v3n_div_cell
   import v3n_pkg::*;
#(
   parameter int W     = 32,
   parameter bit FIRST = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  valid_in,
   input  wire logic [LANES*W-1:0]    rem_in,
   input  wire logic [LANES*QUOT_W-1:0] quot_in,
   input  wire logic [W+3:0]          side_in,  // len, neg[2:0], zero
   output logic                       valid_out,
   output logic [LANES*W-1:0]         rem_out,
   output logic [LANES*QUOT_W-1:0]    quot_out,
   output logic [W+3:0]               side_out
);
   logic                    valid_ff;
   logic [LANES*W-1:0]      rem_ff, rem_nx;
   logic [LANES*QUOT_W-1:0] quot_ff, quot_nx;
   logic [W+3:0]            side_ff;
   logic [W-1:0]            len;

   assign len = side_in[W-1:0];

   always_comb begin
      logic [W:0] t;
      for (int i = 0; i < LANES; i++) begin
         if (FIRST) begin
            t = {1'b0, rem_in[i*W +: W]};
         end else begin
            t = {rem_in[i*W +: W], 1'b0};
         end
         if (t >= {1'b0, len}) begin
            rem_nx[i*W +: W]          = W'(t - {1'b0, len});
            quot_nx[i*QUOT_W +: QUOT_W] = {quot_in[i*QUOT_W +: QUOT_W-1], 1'b1};
         end else begin
            rem_nx[i*W +: W]          = W'(t);
            quot_nx[i*QUOT_W +: QUOT_W] = {quot_in[i*QUOT_W +: QUOT_W-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_nx;
         quot_ff <= quot_nx;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for vector3_normalize_core: directed vectors, then random.
// Depends on v3n_pkg and the core; predicts magnitude and unit vector per word.
`timescale 1ns / 1ps
module tb_top;
   import v3n_pkg::*;

   localparam int LATENCY = 67;
   localparam int NUM_RANDOM = 1030;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] len;
      logic [31:0] uz;
      logic [31:0] uy;
      logic [31:0] ux;
   } norm_word_type;

   typedef struct {
      norm_word_type word;
      logic          zero;
   } norm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   norm_result_type pending_norms[$];
   int mismatches = 0;
   longint cycles = 0;
   bit hold_off = 1'b0;
   bit stim_done = 1'b0;

   always #4 clock = ~clock;

   vector3_normalize_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic norm_result_type normalize(logic [95:0] vec);
      norm_result_type r;
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] q;
      logic [31:0] unit[3];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = vec[32*i+31];
         mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, vec[32*i +: 32]}
                         : {32'd0, vec[32*i +: 32]};
         sum = sum + mag[i] * mag[i];
      end
      len = floor_sqrt(sum);
      r.zero = (len == 0);
      for (int i = 0; i < 3; i++) begin
         if (len == 0) begin
            unit[i] = '0;
         end else begin
            q = (mag[i] << UNIT_FRAC) / len;
            if (neg[i]) q = 64'd0 - q;
            unit[i] = q[31:0];
         end
      end
      r.word = {len[31:0], unit[2], unit[1], unit[0]};
      return r;
   endfunction

   // directed rows; typed-in expectations only where obvious
   typedef struct {
      logic [95:0]     vec;
      bit              known;
      norm_result_type exp;
   } vec_row_type;

   vec_row_type directed[$];

   task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          bit known, logic [31:0] ux, logic [31:0] uy,
                          logic [31:0] uz, logic [31:0] len, logic zero);
      vec_row_type row;
      row.vec = {z, y, x};
      row.known = known;
      row.exp.word = {len, uz, uy, ux};
      row.exp.zero = zero;
      directed.push_back(row);
   endtask

   task automatic send_word(logic [95:0] vec, norm_result_type exp);
      req_tdata <= vec;
      req_tvalid <= 1'b1;
      pending_norms.push_back(exp);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 511)) - 256);
         3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom();
      endcase
   endfunction

   // sender
   initial begin
      logic [95:0] vec;
      int burst;
      add_row(0, 0, 0, 1, 0, 0, 0, 0, 1);
      add_row(32'h0001_0000, 0, 0, 1, 32'h4000_0000, 0, 0, 32'h0001_0000, 0);
      add_row(0, 32'hffff_0000, 0, 1, 0, 32'hc000_0000, 0, 32'h0001_0000, 0);
      add_row(0, 0, 32'h8000_0000, 1, 0, 0, 32'hc000_0000, 32'h8000_0000, 0);
      add_row(32'h7fff_ffff, 0, 0, 1, 32'h4000_0000, 0, 0, 32'h7fff_ffff, 0);
      add_row(1, 0, 0, 1, 32'h4000_0000, 0, 0, 1, 0);
      add_row(32'hffff_ffff, 0, 0, 1, 32'hc000_0000, 0, 0, 1, 0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
      add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
      add_row(32'h8000_0000, 32'h7fff_ffff, 1, 0, 0, 0, 0, 0, 0);
      add_row(3, 4, 0, 0, 0, 0, 0, 0, 0);
      add_row(32'hfffd_0000, 32'h0004_0000, 32'h000c_0000, 0, 0, 0, 0, 0, 0);
      add_row(1, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 0, 0, 0, 0, 0, 0);
      add_row(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 0, 0, 0, 0, 0, 0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_word(directed[i].vec,
                   directed[i].known ? directed[i].exp : normalize(directed[i].vec));
      idle_sender(1);
      // let everything drain before the random part
      wait (pending_norms.size() == 0);
      @(posedge clock);
      for (int n = 0; n < NUM_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         if (n > 300 && n < 360) hold_off = 1'b1;
         else hold_off = 1'b0;
         for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
            vec = {rand_comp(), rand_comp(), rand_comp()};
            send_word(vec, normalize(vec));
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: stall pattern plus one long hold-off
   initial begin
      int phase;
      int long_done;
      phase = 0;
      long_done = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !long_done) begin
            long_done = 1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         phase = (phase + 1) % 64;
         if (phase < 20) rsp_tready <= 1'b1;
         else rsp_tready <= ((phase % 3) != 0) || ($urandom_range(0, 3) == 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      norm_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_norms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            exp = pending_norms.pop_front();
            if (rsp_tdata !== exp.word || rsp_tuser[0] !== exp.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp ux=%h uy=%h uz=%h len=%h zero=%b got %h %h %h %h %b",
                     exp.word.ux, exp.word.uy, exp.word.uz, exp.word.len, exp.zero,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                     rsp_tdata[127:96], rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_norms.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && pending_norms.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hdl
hdl/v3n_pkg.sv
hdl/v3n_sqrt_cell.sv
hdl/v3n_div_cell.sv
hdl/vector3_normalize_core.sv
tb/tb_top.sv
